// File: hdl/rect_edge_snap_top_defines.svh
// assertion macros for the rect_edge_snap checker
// used by res_chk.sv; no other dependencies
`ifndef RECT_EDGE_SNAP_TOP_DEFINES_SVH
`define RECT_EDGE_SNAP_TOP_DEFINES_SVH

// concurrent assertion on an explicit clock and reset
`define RES_ASSERT_CLK(label, clk_sig, rst_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (prop)) \
    else $error(msg);

// concurrent assertion on the checker's clk and rst
`define RES_ASSERT(label, prop, msg) `RES_ASSERT_CLK(label, clk, rst, prop, msg)

`endif

// File: hdl/res_pkg.sv
// shared types and constants for the rectangle edge snap block
// no dependencies
`default_nettype none

package res_pkg;

  localparam int FUNC_W      = 2;
  localparam int MARGIN_W    = 8;
  localparam int COUNT_OUT_W = 6;
  localparam int APB_DATA_W  = 32;
  localparam int APB_ADDR_W  = 3;

  // item function codes
  typedef enum logic [FUNC_W-1:0] {
    FN_CLEAR  = 2'd0,
    FN_APPEND = 2'd1,
    FN_QUERY  = 2'd2
  } func_t;

  // register index, taken from paddr[2]
  localparam logic REG_MARGIN_X = 1'b0;
  localparam logic REG_MARGIN_Y = 1'b1;

  localparam logic [MARGIN_W-1:0] MARGIN_RESET = 8'd16;

  // scan status toward the decision stage
  typedef struct packed {
    logic done;
    logic have_l;
    logic have_r;
    logic have_t;
    logic have_b;
  } scan_stat_t;

endpackage

`default_nettype wire

// File: hdl/res_req_if.sv
// request channel: one item word with valid/ready
// depends on res_pkg
`default_nettype none

interface res_req_if #(parameter int COORD_BITS = 16);
  logic                           valid;
  logic                           ready;
  logic [res_pkg::FUNC_W-1:0]     func;
  logic signed [COORD_BITS-1:0]   pos_x;
  logic signed [COORD_BITS-1:0]   pos_y;
  logic [COORD_BITS-2:0]          pos_w;
  logic [COORD_BITS-2:0]          pos_h;
  logic                           no_move;
  logic                           no_size;
  logic signed [COORD_BITS-1:0]   edge_left;
  logic signed [COORD_BITS-1:0]   edge_top;
  logic signed [COORD_BITS-1:0]   edge_right;
  logic signed [COORD_BITS-1:0]   edge_bottom;

  modport source (
    output valid, func, pos_x, pos_y, pos_w, pos_h, no_move, no_size,
           edge_left, edge_top, edge_right, edge_bottom,
    input  ready
  );

  modport sink (
    input  valid, func, pos_x, pos_y, pos_w, pos_h, no_move, no_size,
           edge_left, edge_top, edge_right, edge_bottom,
    output ready
  );
endinterface

`default_nettype wire

// File: hdl/res_rsp_if.sv
// response channel: one result word with valid/ready
// depends on res_pkg
`default_nettype none

interface res_rsp_if #(parameter int COORD_BITS = 16);
  logic                              valid;
  logic                              ready;
  logic signed [COORD_BITS-1:0]      new_x;
  logic signed [COORD_BITS-1:0]      new_y;
  logic [COORD_BITS-2:0]             new_w;
  logic [COORD_BITS-2:0]             new_h;
  logic [res_pkg::COUNT_OUT_W-1:0]   stored_count;
  logic                              table_full;

  modport source (
    output valid, new_x, new_y, new_w, new_h, stored_count, table_full,
    input  ready
  );

  modport sink (
    input  valid, new_x, new_y, new_w, new_h, stored_count, table_full,
    output ready
  );
endinterface

`default_nettype wire

// File: hdl/rect_edge_snap_top.sv
// rectangle edge snap top level: apb margins, item control, obstacle table
// depends on res_pkg, res_req_if, res_rsp_if, res_ram, res_scan, res_decide
//
//   channel   dir   handshake        word
//   req       in    valid/ready      func, proposed rect, flags, edges
//   rsp       out   valid/ready      new rect, stored_count, table_full
//   apb       in    psel/penable     snap_margin_x at 0x0, snap_margin_y at 0x4
//
// clear and append go from ST_IDLE to ST_FIN, which loads the result into the
// output register once it is free; a query first passes ST_SCAN, which reads
// stored_count table entries at one ram read per cycle, and ST_DECIDE. The next
// item can be taken in the same cycle as the result is offered. One item is
// in work. req.ready is high only while idle; a finished result waits in the
// output register, and a new item is taken while it waits. Reset empties the
// table at once through the count; no clearing pass.
`default_nettype none

module rect_edge_snap_top #(
  parameter int MAX_RECTS  = 32,
  parameter int COORD_BITS = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [res_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [res_pkg::APB_DATA_W-1:0]   pwdata,
  output logic      [res_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                  pready,
  res_req_if.sink                               req,
  res_rsp_if.source                             rsp
);

  localparam int C     = COORD_BITS;
  localparam int D     = COORD_BITS + 3;
  localparam int CNT_W = $clog2(MAX_RECTS + 1);
  localparam int AW    = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_FIN
  } state_t;

  state_t state;

  // margin registers
  logic [res_pkg::MARGIN_W-1:0] margin_x, margin_y;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      margin_x <= res_pkg::MARGIN_RESET;
      margin_y <= res_pkg::MARGIN_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        res_pkg::REG_MARGIN_X: margin_x <= pwdata[res_pkg::MARGIN_W-1:0];
        res_pkg::REG_MARGIN_Y: margin_y <= pwdata[res_pkg::MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      res_pkg::REG_MARGIN_X: prdata = res_pkg::APB_DATA_W'(margin_x);
      res_pkg::REG_MARGIN_Y: prdata = res_pkg::APB_DATA_W'(margin_y);
      default:               prdata = '0;
    endcase
  end

  // input word capture
  logic                accept;
  logic                is_query;
  logic signed [C-1:0] it_x, it_y, it_el, it_et, it_er, it_eb;
  logic [C-2:0]        it_w, it_h;
  logic                it_no_move, it_no_size;

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (accept) begin
      is_query   <= (req.func == res_pkg::FN_QUERY);
      it_x       <= req.pos_x;
      it_y       <= req.pos_y;
      it_w       <= req.pos_w;
      it_h       <= req.pos_h;
      it_no_move <= req.no_move;
      it_no_size <= req.no_size;
      it_el      <= req.edge_left;
      it_et      <= req.edge_top;
      it_er      <= req.edge_right;
      it_eb      <= req.edge_bottom;
    end
  end

  // obstacle table
  logic [CNT_W-1:0] count;
  logic             not_full;
  logic             tbl_we;
  logic             tbl_re;
  logic [AW-1:0]    tbl_raddr;
  logic [4*C-1:0]   tbl_rdata;

  assign not_full = (count < CNT_W'(MAX_RECTS));
  assign tbl_we   = accept && (req.func == res_pkg::FN_APPEND) && not_full;

  res_ram #(
    .WIDTH (4 * C),
    .DEPTH (MAX_RECTS)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (count[AW-1:0]),
    .wdata ({req.edge_bottom, req.edge_right, req.edge_top, req.edge_left}),
    .re    (tbl_re),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  // scan over the stored rectangles
  logic                 kick;
  logic signed [D-1:0]  best_l, best_r, best_t, best_b;
  res_pkg::scan_stat_t  scan_stat;

  res_scan #(
    .MAX_RECTS  (MAX_RECTS),
    .COORD_BITS (COORD_BITS)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .start    (kick),
    .count    (count),
    .pos_x    (it_x),
    .pos_y    (it_y),
    .pos_w    (it_w),
    .pos_h    (it_h),
    .margin_x (margin_x),
    .margin_y (margin_y),
    .rd_en    (tbl_re),
    .rd_addr  (tbl_raddr),
    .rd_data  (tbl_rdata),
    .best_l   (best_l),
    .best_r   (best_r),
    .best_t   (best_t),
    .best_b   (best_b),
    .stat     (scan_stat)
  );

  // snap decision
  logic signed [C-1:0] dec_x, dec_y;
  logic [C-2:0]        dec_w, dec_h;
  logic                dec_valid;

  res_decide #(
    .COORD_BITS (COORD_BITS)
  ) u_decide (
    .clk         (clk),
    .rst         (rst),
    .go          (scan_stat.done),
    .pos_x       (it_x),
    .pos_y       (it_y),
    .pos_w       (it_w),
    .pos_h       (it_h),
    .no_move     (it_no_move),
    .no_size     (it_no_size),
    .edge_left   (it_el),
    .edge_top    (it_et),
    .edge_right  (it_er),
    .edge_bottom (it_eb),
    .margin_x    (margin_x),
    .margin_y    (margin_y),
    .best_l      (best_l),
    .best_r      (best_r),
    .best_t      (best_t),
    .best_b      (best_b),
    .stat        (scan_stat),
    .new_x       (dec_x),
    .new_y       (dec_y),
    .new_w       (dec_w),
    .new_h       (dec_h),
    .valid       (dec_valid)
  );

  // item sequencing, table count and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      kick      <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      kick <= accept && (req.func == res_pkg::FN_QUERY);
      if (rsp.valid && rsp.ready && (state != ST_FIN)) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req.valid) begin
            case (req.func)
              res_pkg::FN_CLEAR:  count <= '0;
              res_pkg::FN_APPEND: if (not_full) count <= count + 1'b1;
              default: ;
            endcase
            if (req.func == res_pkg::FN_QUERY) begin
              state <= ST_SCAN;
            end else begin
              state <= ST_FIN;
            end
          end
        end
        ST_SCAN: begin
          if (scan_stat.done) state <= ST_DECIDE;
        end
        ST_DECIDE: begin
          if (dec_valid) state <= ST_FIN;
        end
        ST_FIN: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid        <= 1'b1;
            rsp.new_x        <= is_query ? dec_x : '0;
            rsp.new_y        <= is_query ? dec_y : '0;
            rsp.new_w        <= is_query ? dec_w : '0;
            rsp.new_h        <= is_query ? dec_h : '0;
            rsp.stored_count <= res_pkg::COUNT_OUT_W'(count);
            rsp.table_full   <= !not_full;
            state            <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hdl/res_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module res_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: hdl/res_scan.sv
// table scan: reads one stored rectangle per cycle and keeps the nearest
// edge offsets in four directions; depends on res_pkg and drives res_ram reads
`default_nettype none

module res_scan #(
  parameter int MAX_RECTS  = 32,
  parameter int COORD_BITS = 16,
  localparam int C     = COORD_BITS,
  localparam int D     = COORD_BITS + 3,
  localparam int CNT_W = $clog2(MAX_RECTS + 1),
  localparam int AW    = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  input  wire logic [CNT_W-1:0]                 count,
  input  wire logic signed [C-1:0]              pos_x,
  input  wire logic signed [C-1:0]              pos_y,
  input  wire logic [C-2:0]                     pos_w,
  input  wire logic [C-2:0]                     pos_h,
  input  wire logic [res_pkg::MARGIN_W-1:0]     margin_x,
  input  wire logic [res_pkg::MARGIN_W-1:0]     margin_y,
  output logic                                  rd_en,
  output logic [AW-1:0]                         rd_addr,
  input  wire logic [4*C-1:0]                   rd_data,
  output logic signed [D-1:0]                   best_l,
  output logic signed [D-1:0]                   best_r,
  output logic signed [D-1:0]                   best_t,
  output logic signed [D-1:0]                   best_b,
  output res_pkg::scan_stat_t                   stat
);

  function automatic logic [D-1:0] mag(input logic signed [D-1:0] v);
    return v[D-1] ? -v : v;
  endfunction

  logic             busy;
  logic [CNT_W-1:0] idx;
  logic             issue;
  logic             rd_valid;
  logic             a_valid;

  // query edges, latched at start
  logic signed [D-1:0] q_l, q_t, q_r, q_b, q_mx, q_my;

  // read address stream
  assign issue   = busy && (idx < count);
  assign rd_en   = issue;
  assign rd_addr = idx[AW-1:0];

  // stage a: offsets of the obstacle just read
  logic signed [D-1:0] obs_l, obs_t, obs_r, obs_b;
  logic signed [D-1:0] c_l1, c_l2, c_r1, c_r2, c_t1, c_t2, c_b1, c_b2;
  logic                ov_v, ov_h;

  assign obs_l = D'($signed(rd_data[C-1:0]));
  assign obs_t = D'($signed(rd_data[2*C-1:C]));
  assign obs_r = D'($signed(rd_data[3*C-1:2*C]));
  assign obs_b = D'($signed(rd_data[4*C-1:3*C]));

  assign ov_v = (q_t < obs_b + q_my) && (q_b > obs_t - q_my);
  assign ov_h = (q_l < obs_r + q_mx) && (q_r > obs_l - q_mx);

  assign c_l1 = obs_l - q_l;
  assign c_l2 = obs_r - q_l;
  assign c_r1 = obs_l - q_r;
  assign c_r2 = obs_r - q_r;
  assign c_t1 = obs_t - q_t;
  assign c_t2 = obs_b - q_t;
  assign c_b1 = obs_t - q_b;
  assign c_b2 = obs_b - q_b;

  // per obstacle its right or bottom edge wins only when strictly nearer
  logic signed [D-1:0] a_pick_l, a_pick_r, a_pick_t, a_pick_b;
  logic [D-1:0]        a_mag_l, a_mag_r, a_mag_t, a_mag_b;
  logic                a_ov_v, a_ov_h;

  always_ff @(posedge clk) begin
    if (rd_valid) begin
      a_ov_v   <= ov_v;
      a_ov_h   <= ov_h;
      a_pick_l <= (mag(c_l2) < mag(c_l1)) ? c_l2 : c_l1;
      a_mag_l  <= (mag(c_l2) < mag(c_l1)) ? mag(c_l2) : mag(c_l1);
      a_pick_r <= (mag(c_r2) < mag(c_r1)) ? c_r2 : c_r1;
      a_mag_r  <= (mag(c_r2) < mag(c_r1)) ? mag(c_r2) : mag(c_r1);
      a_pick_t <= (mag(c_t2) < mag(c_t1)) ? c_t2 : c_t1;
      a_mag_t  <= (mag(c_t2) < mag(c_t1)) ? mag(c_t2) : mag(c_t1);
      a_pick_b <= (mag(c_b2) < mag(c_b1)) ? c_b2 : c_b1;
      a_mag_b  <= (mag(c_b2) < mag(c_b1)) ? mag(c_b2) : mag(c_b1);
    end
  end

  // stage b: keep the first strictly nearer candidate
  logic [D-1:0] mag_l, mag_r, mag_t, mag_b;
  logic         upd_l, upd_r, upd_t, upd_b;

  assign upd_l = a_valid && a_ov_v && (!stat.have_l || (a_mag_l < mag_l));
  assign upd_r = a_valid && a_ov_v && (!stat.have_r || (a_mag_r < mag_r));
  assign upd_t = a_valid && a_ov_h && (!stat.have_t || (a_mag_t < mag_t));
  assign upd_b = a_valid && a_ov_h && (!stat.have_b || (a_mag_b < mag_b));

  // best offsets and query latch
  always_ff @(posedge clk) begin
    if (start) begin
      q_l    <= D'(pos_x);
      q_t    <= D'(pos_y);
      q_r    <= D'(pos_x) + $signed(D'(pos_w));
      q_b    <= D'(pos_y) + $signed(D'(pos_h));
      q_mx   <= $signed(D'(margin_x));
      q_my   <= $signed(D'(margin_y));
      best_l <= '0;
      best_r <= '0;
      best_t <= '0;
      best_b <= '0;
      mag_l  <= '0;
      mag_r  <= '0;
      mag_t  <= '0;
      mag_b  <= '0;
    end else begin
      if (upd_l) begin
        best_l <= a_pick_l;
        mag_l  <= a_mag_l;
      end
      if (upd_r) begin
        best_r <= a_pick_r;
        mag_r  <= a_mag_r;
      end
      if (upd_t) begin
        best_t <= a_pick_t;
        mag_t  <= a_mag_t;
      end
      if (upd_b) begin
        best_b <= a_pick_b;
        mag_b  <= a_mag_b;
      end
    end
  end

  // scan control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      idx      <= '0;
      rd_valid <= 1'b0;
      a_valid  <= 1'b0;
      stat     <= '0;
    end else begin
      rd_valid  <= issue;
      a_valid   <= rd_valid;
      stat.done <= !start && busy && !issue && !rd_valid && !a_valid;
      if (start) begin
        busy        <= 1'b1;
        idx         <= '0;
        stat.have_l <= 1'b0;
        stat.have_r <= 1'b0;
        stat.have_t <= 1'b0;
        stat.have_b <= 1'b0;
      end else begin
        if (issue) begin
          idx <= idx + 1'b1;
        end
        if (busy && !issue && !rd_valid && !a_valid) begin
          busy <= 1'b0;
        end
        if (upd_l) stat.have_l <= 1'b1;
        if (upd_r) stat.have_r <= 1'b1;
        if (upd_t) stat.have_t <= 1'b1;
        if (upd_b) stat.have_b <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/res_decide.sv
// snap decision: picks move or resize snapping from the scan offsets
// and saturates the result; depends on res_pkg
`default_nettype none

module res_decide #(
  parameter int COORD_BITS = 16,
  localparam int C = COORD_BITS,
  localparam int D = COORD_BITS + 3
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         go,
  input  wire logic signed [C-1:0]          pos_x,
  input  wire logic signed [C-1:0]          pos_y,
  input  wire logic [C-2:0]                 pos_w,
  input  wire logic [C-2:0]                 pos_h,
  input  wire logic                         no_move,
  input  wire logic                         no_size,
  input  wire logic signed [C-1:0]          edge_left,
  input  wire logic signed [C-1:0]          edge_top,
  input  wire logic signed [C-1:0]          edge_right,
  input  wire logic signed [C-1:0]          edge_bottom,
  input  wire logic [res_pkg::MARGIN_W-1:0] margin_x,
  input  wire logic [res_pkg::MARGIN_W-1:0] margin_y,
  input  wire logic signed [D-1:0]          best_l,
  input  wire logic signed [D-1:0]          best_r,
  input  wire logic signed [D-1:0]          best_t,
  input  wire logic signed [D-1:0]          best_b,
  input  res_pkg::scan_stat_t               stat,
  output logic signed [C-1:0]               new_x,
  output logic signed [C-1:0]               new_y,
  output logic [C-2:0]                      new_w,
  output logic [C-2:0]                      new_h,
  output logic                              valid
);

  localparam logic signed [D-1:0] CMAX = D'((64'sd1 <<< (C - 1)) - 64'sd1);
  localparam logic signed [D-1:0] CMIN = -CMAX - D'(1);

  function automatic logic [D-1:0] mag(input logic signed [D-1:0] v);
    return v[D-1] ? -v : v;
  endfunction

  logic signed [D-1:0] l, t, w, h, r, b, el, et, er, eb, rw, rh;
  logic [D-1:0]        mx, my, mdl, mdr, mdt, mdb;

  assign l  = D'(pos_x);
  assign t  = D'(pos_y);
  assign w  = $signed(D'(pos_w));
  assign h  = $signed(D'(pos_h));
  assign r  = l + w;
  assign b  = t + h;
  assign el = D'(edge_left);
  assign et = D'(edge_top);
  assign er = D'(edge_right);
  assign eb = D'(edge_bottom);
  assign rw = er - el;
  assign rh = eb - et;
  assign mx = D'(margin_x);
  assign my = D'(margin_y);
  assign mdl = mag(best_l);
  assign mdr = mag(best_r);
  assign mdt = mag(best_t);
  assign mdb = mag(best_b);

  // first stage: which snap applies
  logic                move_c, size_c, snap_x_c, snap_y_c;
  logic                wres_r_c, wres_l_c, hres_b_c, hres_t_c;
  logic signed [D-1:0] dx_c, dy_c, wsum_r, wdif_l, hsum_b, hdif_t;

  assign move_c   = !no_move && (w == rw) && (h == rh) && ((l != el) || (t != et));
  assign size_c   = !move_c && !no_size;
  assign dx_c     = (mdr < mdl) ? best_r : best_l;
  assign dy_c     = (mdb < mdt) ? best_b : best_t;
  assign snap_x_c = stat.have_l && (mag(dx_c) < mx);
  assign snap_y_c = stat.have_t && (mag(dy_c) < my);
  assign wsum_r   = w + best_r;
  assign wdif_l   = w - best_l;
  assign hsum_b   = h + best_b;
  assign hdif_t   = h - best_t;
  assign wres_r_c = (w != rw) && (l == el) && stat.have_r && (mdr < mx) && (wsum_r > 0);
  assign wres_l_c = (w != rw) && !wres_r_c && (r == er) && stat.have_l && (mdl < mx)
                    && (wdif_l > 0);
  assign hres_b_c = (h != rh) && (t == et) && stat.have_b && (mdb < my) && (hsum_b > 0);
  assign hres_t_c = (h != rh) && !hres_b_c && (b == eb) && stat.have_t && (mdt < my)
                    && (hdif_t > 0);

  logic                move_q, size_q, snap_x_q, snap_y_q;
  logic                wres_r_q, wres_l_q, hres_b_q, hres_t_q;
  logic signed [D-1:0] dx_q, dy_q;

  always_ff @(posedge clk) begin
    if (go) begin
      move_q   <= move_c;
      size_q   <= size_c;
      snap_x_q <= snap_x_c;
      snap_y_q <= snap_y_c;
      wres_r_q <= wres_r_c;
      wres_l_q <= wres_l_c;
      hres_b_q <= hres_b_c;
      hres_t_q <= hres_t_c;
      dx_q     <= dx_c;
      dy_q     <= dy_c;
    end
  end

  // second stage: new geometry before saturation
  logic signed [D-1:0] nx, ny, nw, nh;

  always_comb begin
    nx = l;
    ny = t;
    nw = w;
    nh = h;
    if (move_q) begin
      if (snap_x_q) nx = l + dx_q;
      if (snap_y_q) ny = t + dy_q;
    end else if (size_q) begin
      if (wres_r_q) begin
        nw = w + best_r;
      end else if (wres_l_q) begin
        nw = w - best_l;
        nx = l + best_l;
      end
      if (hres_b_q) begin
        nh = h + best_b;
      end else if (hres_t_q) begin
        nh = h - best_t;
        ny = t + best_t;
      end
    end
  end

  // saturate into the field ranges
  logic stage1;

  always_ff @(posedge clk) begin
    if (stage1) begin
      new_x <= (nx < CMIN) ? C'(CMIN) : ((nx > CMAX) ? C'(CMAX) : C'(nx));
      new_y <= (ny < CMIN) ? C'(CMIN) : ((ny > CMAX) ? C'(CMAX) : C'(ny));
      new_w <= (nw < 0) ? '0 : ((nw > CMAX) ? (C-1)'(CMAX) : (C-1)'(nw));
      new_h <= (nh < 0) ? '0 : ((nh > CMAX) ? (C-1)'(CMAX) : (C-1)'(nh));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage1 <= 1'b0;
      valid  <= 1'b0;
    end else begin
      stage1 <= go;
      valid  <= stage1;
    end
  end

endmodule

`default_nettype wire

// File: hdl/res_chk.sv
// port-level checker for rect_edge_snap_top, attached by bind
// depends on res_pkg, rect_edge_snap_top_defines.svh and rect_edge_snap_top
`default_nettype none
`include "rect_edge_snap_top_defines.svh"

module res_chk #(
  parameter int MAX_RECTS  = 32,
  parameter int COORD_BITS = 16
) (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              req_valid,
  input wire logic                              req_ready,
  input wire logic                              rsp_valid,
  input wire logic                              rsp_ready,
  input wire logic signed [COORD_BITS-1:0]      rsp_new_x,
  input wire logic [res_pkg::COUNT_OUT_W-1:0]   rsp_stored_count,
  input wire logic                              rsp_table_full
);

  // one item in work: the word after an accept is never taken at once
  `RES_ASSERT(a_one_in_work, req_valid && req_ready |=> !req_ready, "item taken while busy")

  // full flag agrees with the count
  `RES_ASSERT(a_full_flag, rsp_valid |-> (MAX_RECTS > 63) || (rsp_table_full == (rsp_stored_count == 6'(MAX_RECTS))), "full flag and count disagree")

  // count never passes the table size
  `RES_ASSERT(a_count_bound, rsp_valid |-> (MAX_RECTS > 63) || (rsp_stored_count <= 6'(MAX_RECTS)), "count beyond table size")

  // a stalled result holds
  `RES_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_new_x) && $stable(rsp_stored_count), "stalled result changed")

endmodule

bind rect_edge_snap_top res_chk #(
  .MAX_RECTS  (MAX_RECTS),
  .COORD_BITS (COORD_BITS)
) u_res_chk (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_new_x        (rsp.new_x),
  .rsp_stored_count (rsp.stored_count),
  .rsp_table_full   (rsp.table_full)
);

`default_nettype wire
